// ===== rtl/core/tel_pkg.sv =====
// ----------------------------------------------------------------------------
// tel_pkg: shared types and constants of the timer expiry list
// Sizes, command codes and the structs passed along the row of list cells.
// ----------------------------------------------------------------------------
package tel_pkg;

  localparam int TIMERS    = 16;
  localparam int TIME_BITS = 32;
  localparam int ID_W      = 4;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_MOD  = 2'd2,
    CMD_SCAN = 2'd3
  } tel_cmd_e;

  // broadcast to every cell
  typedef struct packed {
    logic                 by_exp;   // match on expiry instead of id
    logic                 apply;    // remove the first matching entry
    logic                 load;     // append new entry at the tail
    logic [ID_W-1:0]      key_id;
    logic [TIME_BITS-1:0] new_exp;
    logic [TIME_BITS-1:0] now;
  } tel_ctrl_t;

  // passed from head toward tail
  typedef struct packed {
    logic            hit_any;  // a match at or before this cell
    logic            two;      // two or more matches so far
    logic [ID_W-1:0] fid;      // id of the first match
  } tel_chain_t;

endpackage

// ===== rtl/core/timer_expiry_list_core.sv =====
// ----------------------------------------------------------------------------
// timer_expiry_list_core: ordered list of armed timers
// Add, delete, modify and scan requests on a row of list cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, one per handshake. Add, delete and
//   modify act on the list in the cycle they are accepted and give a single
//   response in the next cycle. Scan latches the current time, then, while
//   the output register is free, removes the first expired entry of the list
//   each cycle and reports it, in list order; tlast marks the final report.
//   With nothing expired, scan gives one response with the fired flag low.
//   The removal step sets the pace, one entry per cycle through the cell row
//   as long as the receiver takes the responses; a stall pauses it.
//   The block takes a new request only once the previous scan is finished;
//   the output register lets that request be accepted in the same cycle the
//   last response is taken.
//   Reset clears all valid bits: the list comes up empty, no timer pending.
//   When the receiver stalls (m_axis_tready low), the response holds and the
//   scan pauses with the list unchanged until the response is taken.
// ----------------------------------------------------------------------------
module timer_expiry_list_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] cmd, [5:2] timer_id, [37:6] expiry, [69:38] now, [71:70] zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] fire_id, [4] status, [7:5] zero
  output logic [7:0]  m_axis_tdata,
  // [0] fired
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int IDW = tel_pkg::ID_W;
  localparam int TB  = tel_pkg::TIME_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                 state_q;
  logic                   out_valid_q, out_fired_q, out_status_q, out_last_q;
  logic [IDW-1:0]         out_id_q;
  logic [IDW-1:0]         key_id_q;
  logic [TB-1:0]          now_q;

  tel_pkg::tel_cmd_e      cmd;
  logic [IDW-1:0]         in_id;
  logic [TB-1:0]          in_exp;
  logic [TB-1:0]          in_now;
  logic                   out_free, in_fire, in_range, pending, scan_step;
  logic                   out_load;
  tel_pkg::tel_ctrl_t     ctrl;
  tel_pkg::tel_chain_t    res;

  // request fields
  assign cmd    = tel_pkg::tel_cmd_e'(s_axis_tdata[1:0]);
  assign in_id  = s_axis_tdata[5:2];
  assign in_exp = s_axis_tdata[37:6];
  assign in_now = s_axis_tdata[69:38];

  // output register is free or drains this cycle
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) & out_free;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign in_range      = {1'b0, in_id} < (IDW+1)'(tel_pkg::TIMERS);
  // in idle the cells match on id, so any hit means the timer is pending
  assign pending       = res.hit_any;
  assign scan_step     = (state_q == ST_SCAN) & out_free;
  // a new response enters the output register this cycle
  assign out_load      = (in_fire & (cmd != tel_pkg::CMD_SCAN)) | scan_step;

  always_comb begin
    ctrl         = '0;
    ctrl.now     = now_q;
    ctrl.new_exp = in_exp;
    ctrl.key_id  = in_id;
    if (state_q == ST_SCAN) begin
      ctrl.by_exp = 1'b1;
      ctrl.key_id = key_id_q;
      ctrl.apply  = scan_step & res.hit_any;
    end else begin
      ctrl.apply = in_fire & in_range &
                   ((cmd == tel_pkg::CMD_DEL) | (cmd == tel_pkg::CMD_MOD));
      ctrl.load  = in_fire & in_range &
                   (((cmd == tel_pkg::CMD_ADD) & ~pending) | (cmd == tel_pkg::CMD_MOD));
    end
  end

  tel_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      out_id_q     <= '0;
      out_fired_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_last_q   <= 1'b0;
      key_id_q     <= '0;
      now_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (cmd == tel_pkg::CMD_SCAN) begin
              now_q    <= in_now;
              key_id_q <= in_id;
              state_q  <= ST_SCAN;
            end else begin
              out_id_q    <= in_id;
              out_fired_q <= 1'b0;
              out_last_q  <= 1'b1;
              if (!in_range) begin
                out_status_q <= 1'b1;
              end else if (cmd == tel_pkg::CMD_ADD) begin
                out_status_q <= pending;
              end else if (cmd == tel_pkg::CMD_DEL) begin
                out_status_q <= ~pending;
              end else begin
                out_status_q <= 1'b0;
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_step) begin
            out_status_q <= 1'b0;
            if (res.hit_any) begin
              out_id_q    <= res.fid;
              out_fired_q <= 1'b1;
              out_last_q  <= ~res.two;
              if (!res.two) begin
                state_q <= ST_IDLE;
              end
            end else begin
              // nothing expired: echo the request
              out_id_q    <= key_id_q;
              out_fired_q <= 1'b0;
              out_last_q  <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_status_q, out_id_q};
  assign m_axis_tuser  = out_fired_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/tel_cell.sv =====
// ----------------------------------------------------------------------------
// tel_cell: one list entry
// Holds id and expiry of one armed timer; shifts toward the head on removal.
// ----------------------------------------------------------------------------
module tel_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tel_pkg::tel_ctrl_t            ctrl_i,
  input  logic                          any_hit_i,
  input  logic                          left_valid_i,
  input  logic                          right_valid_i,
  input  logic [tel_pkg::ID_W-1:0]      right_id_i,
  input  logic [tel_pkg::TIME_BITS-1:0] right_exp_i,
  input  tel_pkg::tel_chain_t           chain_i,
  output tel_pkg::tel_chain_t           chain_o,
  output logic                          valid_o,
  output logic [tel_pkg::ID_W-1:0]      id_o,
  output logic [tel_pkg::TIME_BITS-1:0] exp_o
);

  logic                          valid_q, valid_d;
  logic [tel_pkg::ID_W-1:0]      id_q, id_d;
  logic [tel_pkg::TIME_BITS-1:0] exp_q, exp_d;
  logic [tel_pkg::TIME_BITS-1:0] diff;
  logic                          expired, hit, load_here;

  // wraparound signed difference now - expiry >= 0
  assign diff    = ctrl_i.now - exp_q;
  assign expired = ~diff[tel_pkg::TIME_BITS-1];
  assign hit     = valid_q & (ctrl_i.by_exp ? expired : (id_q == ctrl_i.key_id));

  assign chain_o.hit_any = chain_i.hit_any | hit;
  assign chain_o.two     = chain_i.two | (chain_i.hit_any & hit);
  assign chain_o.fid     = (!chain_i.hit_any && hit) ? id_q : chain_i.fid;

  // tail after this cycle's removal: last valid cell if one goes, else first empty
  assign load_here = ctrl_i.load &
                     (any_hit_i ? (valid_q & ~right_valid_i) : (~valid_q & left_valid_i));

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    exp_d   = exp_q;
    if (load_here) begin
      valid_d = 1'b1;
      id_d    = ctrl_i.key_id;
      exp_d   = ctrl_i.new_exp;
    end else if (ctrl_i.apply && chain_o.hit_any) begin
      valid_d = right_valid_i;
      id_d    = right_id_i;
      exp_d   = right_exp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    exp_q <= exp_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign exp_o   = exp_q;

endmodule

// ===== rtl/core/tel_chain.sv =====
// ----------------------------------------------------------------------------
// tel_chain: row of list cells
// Head at cell 0; entries stay contiguous and in list order.
// ----------------------------------------------------------------------------
module tel_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tel_pkg::tel_ctrl_t  ctrl_i,
  output tel_pkg::tel_chain_t result_o
);

  localparam int N = tel_pkg::TIMERS;

  tel_pkg::tel_chain_t           chain [N+1];
  logic                          valid [N+2];
  logic [tel_pkg::ID_W-1:0]      ids   [N+1];
  logic [tel_pkg::TIME_BITS-1:0] exps  [N+1];

  assign chain[0]    = '0;
  assign valid[0]    = 1'b1;   // left of head counts as occupied
  assign valid[N+1]  = 1'b0;   // right of tail is empty
  assign ids[N]      = '0;
  assign exps[N]     = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    tel_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .any_hit_i     (chain[N].hit_any),
      .left_valid_i  (valid[i]),
      .right_valid_i (valid[i+2]),
      .right_id_i    (ids[i+1]),
      .right_exp_i   (exps[i+1]),
      .chain_i       (chain[i]),
      .chain_o       (chain[i+1]),
      .valid_o       (valid[i+1]),
      .id_o          (ids[i]),
      .exp_o         (exps[i])
    );
  end

  assign result_o = chain[N];

endmodule

// ===== test/timer_expiry_list_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_expiry_list_core_tb: self-checking bench for the timer expiry list
// Drives add, delete, modify and scan requests with random gaps and stalls,
// predicts every response from a private copy of the list and compares each
// response field by field in arrival order.
// ----------------------------------------------------------------------------
module timer_expiry_list_core_tb;

  typedef struct packed {
    logic [tel_pkg::ID_W-1:0] fire_id;
    logic                     fired;
    logic                     status;
    logic                     last;
  } timer_response_t;

  // Private copy of the timer list; turns each accepted request into the
  // responses it must cause and checks them as they come back.
  class timer_list_scoreboard;
    logic [tel_pkg::ID_W-1:0]      row_id  [tel_pkg::TIMERS];
    logic [tel_pkg::TIME_BITS-1:0] row_exp [tel_pkg::TIMERS];
    int unsigned                   row_count;
    bit                            armed   [tel_pkg::TIMERS];
    timer_response_t               due_q[$];
    int unsigned                   errors;

    function new();
      row_count = 0;
      errors    = 0;
      foreach (armed[i]) armed[i] = 1'b0;
    endfunction

    // remove one id and close the gap, list order kept
    function void unlink(logic [tel_pkg::ID_W-1:0] id);
      int unsigned keep;
      keep = 0;
      for (int unsigned r = 0; r < row_count; r++) begin
        if (row_id[r] != id) begin
          row_id[keep]  = row_id[r];
          row_exp[keep] = row_exp[r];
          keep++;
        end
      end
      row_count = keep;
      armed[id] = 1'b0;
    endfunction

    function void link(logic [tel_pkg::ID_W-1:0] id, logic [tel_pkg::TIME_BITS-1:0] exp);
      row_id[row_count]  = id;
      row_exp[row_count] = exp;
      row_count++;
      armed[id] = 1'b1;
    endfunction

    function void note_request(tel_pkg::tel_cmd_e cmd, logic [tel_pkg::ID_W-1:0] id,
                               logic [tel_pkg::TIME_BITS-1:0] exp,
                               logic [tel_pkg::TIME_BITS-1:0] tick_now);
      timer_response_t               rsp;
      timer_response_t               hits[$];
      logic [tel_pkg::TIME_BITS-1:0] diff;
      int unsigned                   keep;
      rsp = '{fire_id: id, fired: 1'b0, status: 1'b0, last: 1'b1};
      case (cmd)
        tel_pkg::CMD_SCAN: begin
          keep = 0;
          for (int unsigned r = 0; r < row_count; r++) begin
            diff = tick_now - row_exp[r];
            if (!diff[tel_pkg::TIME_BITS-1]) begin
              // reached: wraparound difference is zero or positive
              armed[row_id[r]] = 1'b0;
              hits.push_back('{fire_id: row_id[r], fired: 1'b1, status: 1'b0,
                               last: 1'b0});
            end else begin
              row_id[keep]  = row_id[r];
              row_exp[keep] = row_exp[r];
              keep++;
            end
          end
          row_count = keep;
          if (hits.size() == 0) begin
            due_q.push_back(rsp);
          end else begin
            foreach (hits[k]) begin
              rsp      = hits[k];
              rsp.last = (k == hits.size() - 1);
              due_q.push_back(rsp);
            end
          end
        end
        tel_pkg::CMD_ADD: begin
          if (armed[id]) rsp.status = 1'b1;
          else link(id, exp);
          due_q.push_back(rsp);
        end
        tel_pkg::CMD_DEL: begin
          if (armed[id]) unlink(id);
          else rsp.status = 1'b1;
          due_q.push_back(rsp);
        end
        default: begin
          // modify: drop if listed, always re-append at the tail
          if (armed[id]) unlink(id);
          link(id, exp);
          due_q.push_back(rsp);
        end
      endcase
    endfunction

    function void check_response(logic [tel_pkg::ID_W-1:0] fire_id, logic fired,
                                 logic status, logic last);
      timer_response_t want;
      if (due_q.size() == 0) begin
        $error("response with nothing expected: fire_id %0d fired %0b",
               fire_id, fired);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (want.fire_id !== fire_id) begin
        $error("fire_id: expected %0d, actual %0d", want.fire_id, fire_id);
        errors++;
      end
      if (want.fired !== fired) begin
        $error("fired: expected %0b, actual %0b", want.fired, fired);
        errors++;
      end
      if (want.status !== status) begin
        $error("status: expected %0b, actual %0b", want.status, status);
        errors++;
      end
      if (want.last !== last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  timer_list_scoreboard sb = new();

  bit                            tx_idle  = 1'b1;  // sender draws gaps
  bit                            rx_idle  = 1'b1;  // receiver draws stalls
  bit                            hold_req = 1'b0;  // ask receiver for one long stall
  logic [tel_pkg::TIME_BITS-1:0] tick;             // running time base for random part

  always #4 clk_i = ~clk_i;

  timer_expiry_list_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // One request per call; valid stays high into the next call when no gap
  // is drawn, so back-to-back requests never drop valid in between.
  task automatic send_request(input tel_pkg::tel_cmd_e cmd,
                              input logic [tel_pkg::ID_W-1:0] id,
                              input logic [tel_pkg::TIME_BITS-1:0] exp,
                              input logic [tel_pkg::TIME_BITS-1:0] tick_now);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, tick_now, exp, id, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(cmd, id, exp, tick_now);
  endtask

  // Sender goes quiet until every predicted response has been taken.
  task automatic drain_responses();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.due_q.size() != 0);
  endtask

  // Mostly well-formed traffic: expiries a little ahead of the time base,
  // scans that advance it; now and then a fully random time.
  task automatic random_request();
    int unsigned                   pick;
    tel_pkg::tel_cmd_e             cmd;
    logic [tel_pkg::ID_W-1:0]      id;
    logic [tel_pkg::TIME_BITS-1:0] exp;
    logic [tel_pkg::TIME_BITS-1:0] tick_now;
    pick     = $urandom_range(0, 99);
    id       = tel_pkg::ID_W'($urandom_range(0, tel_pkg::TIMERS - 1));
    exp      = ($urandom_range(0, 7) == 0) ? $urandom : tick + $urandom_range(0, 60);
    tick_now = $urandom;
    if (pick < 35) begin
      cmd = tel_pkg::CMD_ADD;
    end else if (pick < 50) begin
      cmd = tel_pkg::CMD_MOD;
    end else if (pick < 65) begin
      cmd = tel_pkg::CMD_DEL;
    end else begin
      cmd  = tel_pkg::CMD_SCAN;
      tick = tick + $urandom_range(0, 30);
      if ($urandom_range(0, 9) != 0) tick_now = tick;
    end
    send_request(cmd, id, exp, tick_now);
  endtask

  // Response side: random stall per response, one long hold on request.
  initial begin : response_sink
    int unsigned stall;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = 300;
      end else begin
        stall = rx_idle ? $urandom_range(0, 7) : 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (m_axis_tvalid !== 1'b1) @(posedge clk_i);
      sb.check_response(m_axis_tdata[tel_pkg::ID_W-1:0], m_axis_tuser, m_axis_tdata[4],
                        m_axis_tlast);
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty scan, ignored add and delete, modify both ways,
    // expiry and time extremes, sign boundary of the wraparound difference
    send_request(tel_pkg::CMD_SCAN, 4'd0,  32'hFFFF_FFFF, 32'h0000_0000);
    send_request(tel_pkg::CMD_DEL,  4'd3,  32'h0000_0000, 32'hFFFF_FFFF);
    send_request(tel_pkg::CMD_ADD,  4'd0,  32'h0000_0000, 32'h0000_0000);
    send_request(tel_pkg::CMD_ADD,  4'd0,  32'h0000_0005, 32'hFFFF_FFFF);
    send_request(tel_pkg::CMD_ADD,  4'd15, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(tel_pkg::CMD_MOD,  4'd0,  32'h0000_0064, 32'h0000_0000);
    send_request(tel_pkg::CMD_MOD,  4'd7,  32'h8000_0000, 32'hFFFF_FFFF);
    send_request(tel_pkg::CMD_DEL,  4'd15, 32'hFFFF_FFFF, 32'h0000_0000);
    // difference 0x7fffffff fires, 0xffffff9b does not
    send_request(tel_pkg::CMD_SCAN, 4'd9,  32'h0000_0000, 32'hFFFF_FFFF);
    // equal time fires
    send_request(tel_pkg::CMD_SCAN, 4'd9,  32'hFFFF_FFFF, 32'h0000_0064);
    // difference exactly 0x80000000 is still in the future
    send_request(tel_pkg::CMD_ADD,  4'd2,  32'h8000_0064, 32'h0000_0000);
    send_request(tel_pkg::CMD_SCAN, 4'd4,  32'h0000_0000, 32'h0000_0064);
    send_request(tel_pkg::CMD_DEL,  4'd2,  32'h0000_0000, 32'h0000_0000);
    // full list, shuffled ids, expiries wrapping past zero: all sixteen fire
    for (int i = 0; i < tel_pkg::TIMERS; i++)
      send_request(tel_pkg::CMD_ADD, tel_pkg::ID_W'((i * 7) % tel_pkg::TIMERS),
                   32'hFFFF_FFF8 + i, $urandom);
    send_request(tel_pkg::CMD_SCAN, 4'd5, $urandom, 32'h0000_0010);

    tick = 32'hFFFF_FA00 + $urandom_range(0, 511);
    for (int ph = 0; ph < 9; ph++) begin
      tx_idle = (ph % 3) != 1;
      rx_idle = $urandom_range(0, 3) != 0;
      if (ph == 2) hold_req = 1'b1;      // receiver stalls, input backs up
      if (ph == 5) drain_responses();    // sender waits for all responses to drain
      for (int k = 0; k < 40; k++) random_request();
    end

    drain_responses();
    repeat (tel_pkg::TIMERS + 4) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
